// File: rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared widths, codes and controller/datapath command types of the
// trilinear volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

   localparam int SIZE_W      = 9;
   localparam int COORD_W     = 16;
   localparam int VOX_W       = 32;
   localparam int LD_ADDR_W   = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int FRAC_W      = 8;
   localparam int POS_W       = COORD_W - FRAC_W;
   localparam int QUEUE_DEPTH = 8;
   localparam int QI_W        = $clog2(QUEUE_DEPTH);
   localparam int CORNER_W    = 3;
   localparam int LERP_W      = 3;
   localparam int DIFF_W      = VOX_W + 1;
   localparam int PROD_W      = DIFF_W + FRAC_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_X_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_SIZE = 2'd2;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;
   localparam logic [LERP_W-1:0]   LERP_Z_LAST = 3'd3;
   localparam logic [LERP_W-1:0]   LERP_X_LAST = 3'd5;
   localparam logic [LERP_W-1:0]   LERP_LAST   = 3'd6;

   typedef struct packed {
      logic                capture;
      logic                load_wr;
      logic                check;
      logic                base1;
      logic                base2;
      logic                rd_en;
      logic [CORNER_W-1:0] corner;
      logic                push_rd;
      logic                lerp_pop;
      logic                lerp_mul;
      logic                lerp_push;
      logic [LERP_W-1:0]   lerp_idx;
      logic                finish;
   } cmd_type;

   typedef struct packed {
      logic oob;
   } status_type;

endpackage

// File: rtl/tvs_if.sv
// ----------------------------------------------------------------------------
// tvs_if
// Valid/ready channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface tvs_req_if import tvs_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [LD_ADDR_W-1:0]     voxel_address;
   logic signed [VOX_W-1:0]  voxel_value;
   logic [COORD_W-1:0]       coord_x;
   logic [COORD_W-1:0]       coord_y;
   logic [COORD_W-1:0]       coord_z;

   modport source (output valid, action, voxel_address, voxel_value,
                   coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, action, voxel_address, voxel_value,
                 coord_x, coord_y, coord_z, output ready);
endinterface

interface tvs_rsp_if import tvs_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic signed [VOX_W-1:0] sample_value;
   logic                    out_of_bounds;

   modport source (output valid, sample_value, out_of_bounds, input ready);
   modport sink (input valid, sample_value, out_of_bounds, output ready);
endinterface

interface tvs_csr_if import tvs_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [SIZE_W-1:0]    write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface

// File: rtl/tvs_ctrl.sv
// ----------------------------------------------------------------------------
// tvs_ctrl
// Sequencer: request intake, corner reads, lerp steps and response handoff.
// ----------------------------------------------------------------------------
module tvs_ctrl import tvs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BASE1,
      ST_BASE2,
      ST_READ,
      ST_DRAIN,
      ST_LPOP,
      ST_LMUL,
      ST_LPUSH,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [CORNER_W-1:0] corner_ff;
   logic [LERP_W-1:0]   lerp_idx_ff;
   logic                rsp_valid_ff;
   logic                accept;
   logic                finish_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd           = '0;
      cmd.capture   = accept && (req_action == ACTION_SAMPLE);
      cmd.load_wr   = accept && (req_action == ACTION_LOAD);
      cmd.check     = (state_ff == ST_CHECK);
      cmd.base1     = (state_ff == ST_BASE1);
      cmd.base2     = (state_ff == ST_BASE2);
      cmd.rd_en     = (state_ff == ST_READ);
      cmd.corner    = corner_ff;
      cmd.push_rd   = ((state_ff == ST_READ) && (corner_ff != '0)) ||
                      (state_ff == ST_DRAIN);
      cmd.lerp_pop  = (state_ff == ST_LPOP);
      cmd.lerp_mul  = (state_ff == ST_LMUL);
      cmd.lerp_push = (state_ff == ST_LPUSH);
      cmd.lerp_idx  = lerp_idx_ff;
      cmd.finish    = finish_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         corner_ff    <= '0;
         lerp_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_action == ACTION_SAMPLE)) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               state_ff <= ST_BASE1;
            end
            ST_BASE1: begin
               if (status.oob) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_BASE2;
               end
            end
            ST_BASE2: begin
               corner_ff <= '0;
               state_ff  <= ST_READ;
            end
            ST_READ: begin
               corner_ff <= corner_ff + 1'b1;
               if (corner_ff == CORNER_LAST) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               lerp_idx_ff <= '0;
               state_ff    <= ST_LPOP;
            end
            ST_LPOP: begin
               state_ff <= ST_LMUL;
            end
            ST_LMUL: begin
               state_ff <= ST_LPUSH;
            end
            ST_LPUSH: begin
               lerp_idx_ff <= lerp_idx_ff + 1'b1;
               if (lerp_idx_ff == LERP_LAST) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_LPOP;
               end
            end
            ST_FINISH: begin
               if (finish_go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // a response appears only out of the finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish step");

   // a pending response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=>
      (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("pending response lost");

   // a sample request starts the bounds check
   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACTION_SAMPLE) |=>
      (state_ff == ST_CHECK))
      else $error("sample request not started");

   // the seventh lerp ends the sample
   a_lerp_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LPUSH && lerp_idx_ff == LERP_LAST) |=>
      (state_ff == ST_FINISH))
      else $error("lerp sequence overran");
`endif

endmodule

// File: rtl/tvs_datapath.sv
// ----------------------------------------------------------------------------
// tvs_datapath
// Size registers, voxel memory, corner addressing, operand queue and the
// shared lerp multiplier.
// ----------------------------------------------------------------------------
module tvs_datapath import tvs_pkg::*; #(
   parameter int MAX_VOXELS = 65536,
   parameter int MAX_AXIS   = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    csr_wr,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [SIZE_W-1:0]       csr_data,
   input  logic [LD_ADDR_W-1:0]    voxel_address,
   input  logic signed [VOX_W-1:0] voxel_value,
   input  logic [COORD_W-1:0]      coord_x,
   input  logic [COORD_W-1:0]      coord_y,
   input  logic [COORD_W-1:0]      coord_z,
   output logic signed [VOX_W-1:0] sample_value,
   output logic                    out_of_bounds
);

   localparam int AW = $clog2(MAX_VOXELS);

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      if (32'(v) > MAX_AXIS) begin
         clamp_size = SIZE_W'(MAX_AXIS);
      end else begin
         clamp_size = v;
      end
   endfunction

   function automatic logic beyond(input logic [COORD_W-1:0] c,
                                   input logic [SIZE_W-1:0] s);
      logic [SIZE_W+FRAC_W-1:0] lim;
      lim    = {s - 1'b1, FRAC_W'(0)};
      beyond = (s == '0) || ((SIZE_W+FRAC_W)'(c) > lim);
   endfunction

   function automatic logic has_next(input logic [POS_W-1:0] p,
                                     input logic [SIZE_W-1:0] s);
      has_next = (SIZE_W'(p) < (s - 1'b1));
   endfunction

   logic [SIZE_W-1:0]        x_size_ff, y_size_ff, z_size_ff;
   logic [COORD_W-1:0]       cx_ff, cy_ff, cz_ff;
   logic                     oob_ff, nx_ff, ny_ff, nz_ff;
   logic [AW-1:0]            xs_ff, xy_ff, t_ff, base_ff;
   logic [AW-1:0]            rd_addr;
   logic [31:0]              ld_addr32;
   logic                     ld_in_range;
   logic [VOX_W-1:0]         mem [MAX_VOXELS];
   logic signed [VOX_W-1:0]  rd_data_ff;
   logic signed [VOX_W-1:0]  q_ff [QUEUE_DEPTH];
   logic [QI_W:0]            q_cnt_ff;
   logic signed [VOX_W-1:0]  a_ff;
   logic signed [DIFF_W-1:0] d_ff;
   logic [FRAC_W-1:0]        f_ff, f_sel;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] lerp_sum;
   logic signed [VOX_W-1:0]  lerp_value;
   logic signed [VOX_W-1:0]  sample_ff;
   logic                     oob_out_ff;

   assign status.oob    = oob_ff;
   assign sample_value  = sample_ff;
   assign out_of_bounds = oob_out_ff;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_size_ff <= SIZE_W'(1);
         y_size_ff <= SIZE_W'(1);
         z_size_ff <= SIZE_W'(1);
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_X_SIZE: x_size_ff <= clamp_size(csr_data);
            CSR_Y_SIZE: y_size_ff <= clamp_size(csr_data);
            CSR_Z_SIZE: z_size_ff <= clamp_size(csr_data);
            default: begin
            end
         endcase
      end
   end

   // coordinate capture, bounds check and base address
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cx_ff <= coord_x;
         cy_ff <= coord_y;
         cz_ff <= coord_z;
      end
      if (cmd.check) begin
         oob_ff <= beyond(cx_ff, x_size_ff) || beyond(cy_ff, y_size_ff) ||
                   beyond(cz_ff, z_size_ff);
         nx_ff  <= has_next(cx_ff[COORD_W-1:FRAC_W], x_size_ff);
         ny_ff  <= has_next(cy_ff[COORD_W-1:FRAC_W], y_size_ff);
         nz_ff  <= has_next(cz_ff[COORD_W-1:FRAC_W], z_size_ff);
         xs_ff  <= AW'(32'(x_size_ff));
         xy_ff  <= AW'(32'(x_size_ff) * 32'(y_size_ff));
      end
      if (cmd.base1) begin
         t_ff <= AW'(32'(cx_ff[COORD_W-1:FRAC_W]) +
                     32'(cy_ff[COORD_W-1:FRAC_W]) * 32'(x_size_ff));
      end
      if (cmd.base2) begin
         base_ff <= AW'(32'(t_ff) + 32'(cz_ff[COORD_W-1:FRAC_W]) * 32'(xy_ff));
      end
   end

   // corner bits: 0 selects z neighbor, 1 x neighbor, 2 y neighbor
   assign rd_addr = base_ff +
                    ((cmd.corner[1] && nx_ff) ? AW'(1) : '0) +
                    ((cmd.corner[2] && ny_ff) ? xs_ff : '0) +
                    ((cmd.corner[0] && nz_ff) ? xy_ff : '0);

   assign ld_addr32   = 32'(voxel_address);
   assign ld_in_range = (ld_addr32 < MAX_VOXELS);

   // voxel memory
   always_ff @(posedge clock) begin
      if (cmd.load_wr && ld_in_range) begin
         mem[ld_addr32[AW-1:0]] <= voxel_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // operand queue: lerps take the two oldest entries and append the result
   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
      end else if (cmd.capture) begin
         q_cnt_ff <= '0;
      end else if (cmd.push_rd) begin
         q_ff[q_cnt_ff[QI_W-1:0]] <= rd_data_ff;
         q_cnt_ff                 <= q_cnt_ff + 1'b1;
      end else if (cmd.lerp_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
            q_ff[i] <= q_ff[i+2];
         end
         q_cnt_ff <= q_cnt_ff - (QI_W+1)'(2);
      end else if (cmd.lerp_push) begin
         q_ff[q_cnt_ff[QI_W-1:0]] <= lerp_value;
         q_cnt_ff                 <= q_cnt_ff + 1'b1;
      end
   end

   // fraction: z for the first four lerps, then x, then y
   always_comb begin
      priority if (cmd.lerp_idx <= LERP_Z_LAST) begin
         f_sel = cz_ff[FRAC_W-1:0];
      end else if (cmd.lerp_idx <= LERP_X_LAST) begin
         f_sel = cx_ff[FRAC_W-1:0];
      end else begin
         f_sel = cy_ff[FRAC_W-1:0];
      end
   end

   assign lerp_sum   = PROD_W'(a_ff) + (prod_ff >>> FRAC_W);
   assign lerp_value = lerp_sum[VOX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.lerp_pop) begin
         a_ff <= q_ff[0];
         d_ff <= DIFF_W'(q_ff[1]) - DIFF_W'(q_ff[0]);
         f_ff <= f_sel;
      end
      if (cmd.lerp_mul) begin
         prod_ff <= d_ff * $signed({1'b0, f_ff});
      end
      if (cmd.finish) begin
         sample_ff  <= oob_ff ? '0 : q_ff[0];
         oob_out_ff <= oob_ff;
      end
   end

`ifndef SYNTHESIS
   // the queue never holds more than the eight corners
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= (QI_W+1)'(QUEUE_DEPTH))
      else $error("operand queue overflow");

   // every lerp finds two operands
   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.lerp_pop |-> (q_cnt_ff >= (QI_W+1)'(2)))
      else $error("lerp pop from short queue");

   // an in-bounds result comes from a single remaining entry
   a_queue_final: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !oob_ff) |-> (q_cnt_ff == (QI_W+1)'(1)))
      else $error("queue not reduced to one entry");
`endif

endmodule

// File: rtl/trilinear_volume_sampler_core.sv
// ----------------------------------------------------------------------------
// trilinear_volume_sampler_core
// Holds a voxel volume loaded one word per request and answers sample
// requests by trilinear interpolation (z, then x, then y). A load request
// writes the memory as it is accepted and gives no response. A sample
// request inside the volume gives one response after the eight corner
// reads through the single memory read port and the seven lerps on the
// shared multiplier; an out-of-bounds sample skips both and answers with
// zero and the flag set. The next request is taken as soon as the response
// sits in the output register. Sizes clamp at MAX_AXIS; the user must write
// them through the register channel only while the block is idle, which the
// block itself does not enforce. MAX_VOXELS is a power of two; sample
// addresses wrap modulo it. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler_core import tvs_pkg::*; #(
   parameter int MAX_VOXELS = 65536,
   parameter int MAX_AXIS   = 256
) (
   input logic       clock,
   input logic       reset,
   tvs_req_if.sink   req_ch,
   tvs_rsp_if.source rsp_ch,
   tvs_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;
   logic       csr_wr;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   tvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd),
      .status     (status)
   );

   tvs_datapath #(
      .MAX_VOXELS (MAX_VOXELS),
      .MAX_AXIS   (MAX_AXIS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_wr        (csr_wr),
      .csr_index     (csr_ch.reg_index),
      .csr_data      (csr_ch.write_data),
      .voxel_address (req_ch.voxel_address),
      .voxel_value   (req_ch.voxel_value),
      .coord_x       (req_ch.coord_x),
      .coord_y       (req_ch.coord_y),
      .coord_z       (req_ch.coord_z),
      .sample_value  (rsp_ch.sample_value),
      .out_of_bounds (rsp_ch.out_of_bounds)
   );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trilinear volume sampler core. Loads voxels and
// issues sample requests through the request channel, checks every response
// against a built-in model of the blend (z, then x, then y, with border reuse
// and the out-of-bounds flag), and sweeps the axis sizes through the register
// channel between phases, including zero, the clamp limit and above it.
// Samples only reach voxels that have been loaded, and both channels stall in
// random bursts except in the closing steady stream.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tvs_pkg::*;

   localparam int VOXEL_COUNT     = 65536;
   localparam int AXIS_LIMIT      = 256;
   localparam int LATENCY_WAIT    = 40;
   localparam int STALL_LIMIT     = 2000;
   localparam int TOTAL_REQUESTS  = 1700;
   localparam int STEADY_REQUESTS = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic signed [VOX_W-1:0] value;
      logic                    oob;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4ns clock = ~clock;

   tvs_req_if req_ch ();
   tvs_rsp_if rsp_ch ();
   tvs_csr_if csr_ch ();

   trilinear_volume_sampler_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [VOX_W-1:0]  volume_mem [VOXEL_COUNT];
   bit                volume_written [VOXEL_COUNT];
   logic [SIZE_W-1:0] axis_size [3];
   sample_type        pending_samples [$];
   sample_type        head;
   int                errors = 0;
   int                requests_sent = 0;
   int                idle_cycles = 0;
   int                rsp_hold = 0;
   bit                quiet = 1'b0;
   bit                tx_gaps = 1'b1;
   bit                rx_stalls = 1'b1;

   function automatic logic [SIZE_W-1:0] clamp_axis(logic [SIZE_W-1:0] raw);
      return (raw > AXIS_LIMIT) ? SIZE_W'(AXIS_LIMIT) : raw;
   endfunction

   function automatic bit past_rim(logic [COORD_W-1:0] c, logic [SIZE_W-1:0] n);
      if (n == 0) begin
         return 1'b1;
      end
      return int'(c) > ((int'(n) - 1) << FRAC_W);
   endfunction

   function automatic bit is_outside(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                     logic [COORD_W-1:0] cz);
      return past_rim(cx, axis_size[CSR_X_SIZE]) || past_rim(cy, axis_size[CSR_Y_SIZE]) ||
             past_rim(cz, axis_size[CSR_Z_SIZE]);
   endfunction

   function automatic int next_step(int pos, logic [SIZE_W-1:0] n);
      return (pos < int'(n) - 1) ? 1 : 0;
   endfunction

   function automatic logic [LD_ADDR_W-1:0] voxel_index(int x, int y, int z);
      longint a;
      a = longint'(x) + longint'(y) * longint'(axis_size[CSR_X_SIZE]) +
          longint'(z) * longint'(axis_size[CSR_X_SIZE]) * longint'(axis_size[CSR_Y_SIZE]);
      return a[LD_ADDR_W-1:0];
   endfunction

   function automatic longint voxel_read(int x, int y, int z);
      return longint'(signed'(volume_mem[voxel_index(x, y, z)]));
   endfunction

   function automatic longint blend(longint a, longint b, logic [FRAC_W-1:0] f);
      longint prod;
      prod = longint'(f) * (b - a);
      return a + (prod >>> FRAC_W);
   endfunction

   function automatic sample_type interpolate_sample(logic [COORD_W-1:0] cx,
                                                     logic [COORD_W-1:0] cy,
                                                     logic [COORD_W-1:0] cz);
      sample_type r;
      int px, py, pz, nx, ny, nz;
      logic [FRAC_W-1:0] fx, fy, fz;
      longint c00, c10, c01, c11, bottom, top, res;
      r.value = '0;
      r.oob = 1'b1;
      if (is_outside(cx, cy, cz)) begin
         return r;
      end
      px = int'(cx[COORD_W-1:FRAC_W]);
      py = int'(cy[COORD_W-1:FRAC_W]);
      pz = int'(cz[COORD_W-1:FRAC_W]);
      fx = cx[FRAC_W-1:0];
      fy = cy[FRAC_W-1:0];
      fz = cz[FRAC_W-1:0];
      nx = next_step(px, axis_size[CSR_X_SIZE]);
      ny = next_step(py, axis_size[CSR_Y_SIZE]);
      nz = next_step(pz, axis_size[CSR_Z_SIZE]);
      c00 = blend(voxel_read(px, py, pz), voxel_read(px, py, pz + nz), fz);
      c10 = blend(voxel_read(px + nx, py, pz), voxel_read(px + nx, py, pz + nz), fz);
      c01 = blend(voxel_read(px, py + ny, pz), voxel_read(px, py + ny, pz + nz), fz);
      c11 = blend(voxel_read(px + nx, py + ny, pz),
                  voxel_read(px + nx, py + ny, pz + nz), fz);
      bottom = blend(c00, c10, fx);
      top = blend(c01, c11, fx);
      res = blend(bottom, top, fy);
      r.value = res[VOX_W-1:0];
      r.oob = 1'b0;
      return r;
   endfunction

   function automatic logic [VOX_W-1:0] pick_voxel();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return VOX_W'($urandom_range(0, 511)) - VOX_W'(256);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 15))
         0: return SIZE_W'(1);
         1: return SIZE_W'(AXIS_LIMIT);
         2: return SIZE_W'($urandom_range(AXIS_LIMIT + 1, 511));
         3: return SIZE_W'($urandom_range(7, AXIS_LIMIT - 1));
         4: return SIZE_W'(0);
         default: return SIZE_W'($urandom_range(2, 6));
      endcase
   endfunction

   // in range unless beyond is set, then just past the last voxel
   function automatic logic [COORD_W-1:0] pick_coord(logic [CSR_IDX_W-1:0] axis, bit beyond);
      int n;
      int rim;
      n = int'(axis_size[axis]);
      if (n == 0) begin
         return COORD_W'($urandom);
      end
      rim = (n - 1) << FRAC_W;
      if (beyond) begin
         return COORD_W'(rim + $urandom_range(1, 255));
      end
      case ($urandom_range(0, 3))
         0: return COORD_W'(rim);
         1: return COORD_W'($urandom_range(0, n - 1) << FRAC_W);
         default: return COORD_W'($urandom_range(0, rim));
      endcase
   endfunction

   task automatic send_request(logic act, logic [LD_ADDR_W-1:0] addr, logic [VOX_W-1:0] val,
                               logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [COORD_W-1:0] cz);
      if (tx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.voxel_address <= addr;
      req_ch.voxel_value   <= val;
      req_ch.coord_x       <= cx;
      req_ch.coord_y       <= cy;
      req_ch.coord_z       <= cz;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      if (act == ACTION_LOAD) begin
         volume_mem[addr] = val;
         volume_written[addr] = 1'b1;
      end else begin
         pending_samples.push_back(interpolate_sample(cx, cy, cz));
      end
      @(negedge clock);
   endtask

   task automatic send_load(logic [LD_ADDR_W-1:0] addr, logic [VOX_W-1:0] val);
      send_request(ACTION_LOAD, addr, val, COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom));
   endtask

   // loads every corner the sample will read that is still empty, or at random on refresh
   task automatic send_sample(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              logic [COORD_W-1:0] cz, bit refresh);
      int px, py, pz, nx, ny, nz;
      logic [LD_ADDR_W-1:0] a;
      if (!is_outside(cx, cy, cz)) begin
         px = int'(cx[COORD_W-1:FRAC_W]);
         py = int'(cy[COORD_W-1:FRAC_W]);
         pz = int'(cz[COORD_W-1:FRAC_W]);
         nx = next_step(px, axis_size[CSR_X_SIZE]);
         ny = next_step(py, axis_size[CSR_Y_SIZE]);
         nz = next_step(pz, axis_size[CSR_Z_SIZE]);
         for (int c = 0; c < 8; c++) begin
            a = voxel_index(px + nx * c[0], py + ny * c[1], pz + nz * c[2]);
            if (!volume_written[a] || (refresh && $urandom_range(0, 1) == 0)) begin
               send_load(a, pick_voxel());
            end
         end
      end
      send_request(ACTION_SAMPLE, LD_ADDR_W'($urandom), VOX_W'($urandom), cx, cy, cz);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
   endtask

   task automatic write_size(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      csr_ch.valid      <= 1'b1;
      csr_ch.reg_index  <= idx;
      csr_ch.write_data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx != CSR_SPARE) begin
         axis_size[idx] = clamp_axis(data);
      end
      @(negedge clock);
   endtask

   task automatic set_sizes(logic [SIZE_W-1:0] x, logic [SIZE_W-1:0] y, logic [SIZE_W-1:0] z);
      settle();
      write_size(CSR_X_SIZE, x);
      write_size(CSR_Y_SIZE, y);
      write_size(CSR_Z_SIZE, z);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_volume_phase(int budget);
      int stop;
      int r;
      int hit;
      stop = requests_sent + budget;
      while (requests_sent < stop) begin
         r = $urandom_range(0, 19);
         hit = $urandom_range(0, 2);
         if (r < 2) begin
            send_load(LD_ADDR_W'($urandom), pick_voxel());
         end else if (r < 4) begin
            send_sample(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 1'b0);
         end else if (r < 6) begin
            send_sample(pick_coord(CSR_X_SIZE, hit == 0), pick_coord(CSR_Y_SIZE, hit == 1),
                        pick_coord(CSR_Z_SIZE, hit == 2), 1'b0);
         end else if (r == 6) begin
            settle();
         end else begin
            send_sample(pick_coord(CSR_X_SIZE, 1'b0), pick_coord(CSR_Y_SIZE, 1'b0),
                        pick_coord(CSR_Z_SIZE, 1'b0), r < 11);
         end
      end
   endtask

   task automatic test_reset_sizes();
      send_load(LD_ADDR_W'(0), 32'h7FFF_FFFF);
      send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_sample(16'h0001, 16'h0000, 16'h0000, 1'b0);
      send_sample(16'h0000, 16'h0100, 16'h0000, 1'b0);
      send_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
   endtask

   task automatic test_blend_extremes();
      set_sizes(SIZE_W'(2), SIZE_W'(2), SIZE_W'(2));
      for (int i = 0; i < 8; i++) begin
         send_load(LD_ADDR_W'(i), (i % 3 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end
      send_sample(16'h0080, 16'h0080, 16'h0080, 1'b0);
      send_sample(16'h00FF, 16'h00FF, 16'h00FF, 1'b0);
      send_sample(16'h0100, 16'h0100, 16'h0100, 1'b0);
      send_sample(16'h0100, 16'h0000, 16'h00FF, 1'b0);
      send_sample(16'h0101, 16'h0000, 16'h0000, 1'b0);
   endtask

   task automatic test_size_limits();
      settle();
      write_size(CSR_SPARE, SIZE_W'(511));
      csr_ch.valid <= 1'b0;
      set_sizes(SIZE_W'(0), SIZE_W'(511), SIZE_W'(300));
      send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
      set_sizes(SIZE_W'(AXIS_LIMIT), SIZE_W'(AXIS_LIMIT), SIZE_W'(AXIS_LIMIT));
      send_sample(16'hFF00, 16'hFF00, 16'hFF00, 1'b1);
   endtask

   task automatic test_random_volumes();
      while (requests_sent < TOTAL_REQUESTS - STEADY_REQUESTS) begin
         tx_gaps = $urandom_range(0, 3) != 0;
         rx_stalls = $urandom_range(0, 3) != 0;
         set_sizes(pick_size(), pick_size(), pick_size());
         run_volume_phase($urandom_range(80, 180));
      end
   endtask

   task automatic test_steady_stream();
      quiet = 1'b1;
      set_sizes(SIZE_W'($urandom_range(2, 5)), SIZE_W'($urandom_range(2, 5)),
                SIZE_W'($urandom_range(2, 5)));
      run_volume_phase(STEADY_REQUESTS);
   endtask

   // response side stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (rx_stalls && !quiet && $urandom_range(0, 11) == 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= $urandom_range(0, 17);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_samples.size() == 0) begin
            errors++;
            $error("unexpected response: sample_value %0d out_of_bounds %0b",
                   rsp_ch.sample_value, rsp_ch.out_of_bounds);
         end else begin
            head = pending_samples.pop_front();
            if (rsp_ch.sample_value !== head.value) begin
               errors++;
               $error("sample_value: expected %0d, actual %0d", head.value,
                      rsp_ch.sample_value);
            end
            if (rsp_ch.out_of_bounds !== head.oob) begin
               errors++;
               $error("out_of_bounds: expected %0b, actual %0b", head.oob,
                      rsp_ch.out_of_bounds);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles < STALL_LIMIT) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.action        = ACTION_LOAD;
      req_ch.voxel_address = '0;
      req_ch.voxel_value   = '0;
      req_ch.coord_x       = '0;
      req_ch.coord_y       = '0;
      req_ch.coord_z       = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.reg_index     = CSR_X_SIZE;
      csr_ch.write_data    = '0;
      axis_size[CSR_X_SIZE] = SIZE_W'(1);
      axis_size[CSR_Y_SIZE] = SIZE_W'(1);
      axis_size[CSR_Z_SIZE] = SIZE_W'(1);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_sizes();
      test_blend_extremes();
      test_size_limits();
      test_random_volumes();
      test_steady_stream();

      settle();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: trilinear_volume_sampler_core.f
rtl/tvs_pkg.sv
rtl/tvs_if.sv
rtl/tvs_ctrl.sv
rtl/tvs_datapath.sv
rtl/trilinear_volume_sampler_core.sv
tb/testbench.sv
